// ----- hw/rtl/ura_pkg.sv -----
// ura_pkg: shared types and constants of the ultrasonic range averager
// phase encoding, register indexes, field widths, controller/datapath structs
// no dependencies
`default_nettype none

package ura_pkg;

	// field widths
	localparam int TRIG_W      = 8;
	localparam int SAMPLE_W    = 5;
	localparam int SETTLE_W    = 20;
	localparam int TPC_W       = 8;
	localparam int DIST_W      = 23;
	localparam int DIVISOR_W   = 12;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 20;
	localparam int ROUNDS_MAX  = 16;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM  = 8'd3;

	// configuration reset values
	localparam logic [TRIG_W-1:0]   TRIG_RST   = 8'd20;
	localparam logic [SAMPLE_W-1:0] SAMPLE_RST = 5'd5;
	localparam logic [SETTLE_W-1:0] SETTLE_RST = 20'd50000;
	localparam logic [TPC_W-1:0]    TPC_RST    = 8'd58;

	// measurement phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_COUNT,
		PH_SETTLE
	} phase_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear;       // new sequence: zero counters and sum
		logic tick_inc;    // advance phase tick counter
		logic tick_clr;    // zero phase tick counter
		logic echo_first;  // first echo-high tick
		logic echo_inc;    // echo still high
		logic round_end;   // fold echo count into sum
		logic div_start;   // launch average division
		logic latch;       // take quotient as new distance
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic trig_last;       // this trigger tick is the last one
		logic settle_last;     // this settle tick is the last one
		logic rounds_met;      // enough rounds collected
		logic round_will_meet; // round ending now is the last one
		logic div_busy;        // division still running
	} dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ura_if.sv -----
// ura_if: valid/ready channel interfaces for tick, result and config beats
// depends on ura_pkg for field widths
`default_nettype none

// tick channel: one beat per microsecond tick
interface ura_tick_if;
	logic valid;
	logic ready;
	logic start_req;
	logic echo_level;

	modport source (output valid, output start_req, output echo_level, input ready);
	modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

// result channel: one beat per accepted tick
interface ura_res_if;
	logic                       valid;
	logic                       ready;
	logic                       trigger;
	logic                       busy_res;
	logic                       done_res;
	logic [ura_pkg::DIST_W-1:0] distance_q4;

	modport source (output valid, output trigger, output busy_res, output done_res,
		output distance_q4, input ready);
	modport sink   (input valid, input trigger, input busy_res, input done_res,
		input distance_q4, output ready);
endinterface

// configuration write channel
interface ura_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ura_pkg::CFG_IDX_W-1:0]  index;
	logic [ura_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ura_div.sv -----
// ura_div: restoring divider, one quotient bit per cycle, saturating result
// depends on ura_pkg for widths
`default_nettype none

module ura_div #(
	parameter int DIVIDEND_W = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [DIVIDEND_W-1:0]         dividend,
	input  wire logic [ura_pkg::DIVISOR_W-1:0] divisor,
	output logic                               busy,
	output logic [ura_pkg::DIST_W-1:0]         quotient
);

	localparam int DW  = ura_pkg::DIVISOR_W;
	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] acc_q;
	logic [DW-1:0]         rem_q;
	logic [DW-1:0]         dvs_q;
	logic [CNT_W-1:0]      cnt_q;

	logic [DW:0]           trial;
	logic                  ge;
	logic [DW:0]           diff;

	// one compare and subtract step
	always_comb begin
		trial = {rem_q, acc_q[DIVIDEND_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			dvs_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIVIDEND_W);
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			acc_q <= {acc_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign busy = (cnt_q != '0);

	// clamp to the distance range
	always_comb begin
		if (|acc_q[DIVIDEND_W-1:ura_pkg::DIST_W])
			quotient = ura_pkg::DIST_MAX;
		else
			quotient = acc_q[ura_pkg::DIST_W-1:0];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ura_dp.sv -----
// ura_dp: config registers, tick and echo counters, echo sum, distance register
// depends on ura_pkg and ura_div
`default_nettype none

module ura_dp #(
	parameter int ECHO_COUNT_BITS = 24
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ura_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire ura_pkg::ctrl_cmd_t             cmd,
	output ura_pkg::dp_status_t                 status,
	output logic [ura_pkg::DIST_W-1:0]          distance_nxt
);

	localparam int SUM_W = ECHO_COUNT_BITS + 4;
	localparam int DVD_W = SUM_W + 4;
	localparam int SW    = ura_pkg::SETTLE_W;
	localparam int PROD_W = ura_pkg::SAMPLE_W + ura_pkg::TPC_W;

	logic [ura_pkg::TRIG_W-1:0]   trig_q;
	logic [ura_pkg::SAMPLE_W-1:0] sample_q;
	logic [SW-1:0]                settle_q;
	logic [ura_pkg::TPC_W-1:0]    tpc_q;

	logic [SW-1:0]                tick_q;
	logic [ECHO_COUNT_BITS-1:0]   echo_q;
	logic [ura_pkg::SAMPLE_W-1:0] rounds_q;
	logic [SUM_W-1:0]             sum_q;
	logic [ura_pkg::DIST_W-1:0]   dist_q;

	logic [SW:0]                  tick_nxt;
	logic [ura_pkg::SAMPLE_W-1:0] wanted;
	logic [ura_pkg::SAMPLE_W:0]   rounds_inc;
	logic [ura_pkg::TPC_W-1:0]    tpc_eff;
	logic [PROD_W-1:0]            divisor_full;
	logic [SUM_W-1:0]             sum_add;
	logic                         div_busy;
	logic [ura_pkg::DIST_W-1:0]   quotient;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q   <= ura_pkg::TRIG_RST;
			sample_q <= ura_pkg::SAMPLE_RST;
			settle_q <= ura_pkg::SETTLE_RST;
			tpc_q    <= ura_pkg::TPC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ura_pkg::REG_TRIGGER_TICKS: trig_q   <= cfg_data[ura_pkg::TRIG_W-1:0];
				ura_pkg::REG_SAMPLE_COUNT:  sample_q <= cfg_data[ura_pkg::SAMPLE_W-1:0];
				ura_pkg::REG_SETTLE_TICKS:  settle_q <= cfg_data[SW-1:0];
				ura_pkg::REG_TICKS_PER_CM:  tpc_q    <= cfg_data[ura_pkg::TPC_W-1:0];
				default: ;
			endcase
		end
	end

	// effective round count and divisor
	always_comb begin
		if (sample_q == '0)
			wanted = ura_pkg::SAMPLE_W'(1);
		else if (sample_q > ura_pkg::SAMPLE_W'(ura_pkg::ROUNDS_MAX))
			wanted = ura_pkg::SAMPLE_W'(ura_pkg::ROUNDS_MAX);
		else
			wanted = sample_q;
		tpc_eff      = (tpc_q == '0) ? ura_pkg::TPC_W'(1) : tpc_q;
		divisor_full = PROD_W'(wanted) * PROD_W'(tpc_eff);
	end

	// status toward the controller
	always_comb begin
		tick_nxt   = {1'b0, tick_q} + (SW+1)'(1);
		rounds_inc = {1'b0, rounds_q} + (ura_pkg::SAMPLE_W+1)'(1);
		sum_add    = sum_q + SUM_W'(echo_q);
		status.trig_last       = tick_nxt >= (SW+1)'(trig_q);
		status.settle_last     = tick_nxt >= {1'b0, settle_q};
		status.rounds_met      = rounds_q >= wanted;
		status.round_will_meet = rounds_inc >= {1'b0, wanted};
		status.div_busy        = div_busy;
	end

	// counters and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			echo_q   <= '0;
			rounds_q <= '0;
			sum_q    <= '0;
			dist_q   <= '0;
		end else begin
			if (cmd.clear || cmd.tick_clr || cmd.round_end)
				tick_q <= '0;
			else if (cmd.tick_inc)
				tick_q <= tick_nxt[SW-1:0];

			if (cmd.clear || cmd.round_end)
				echo_q <= '0;
			else if (cmd.echo_first)
				echo_q <= ECHO_COUNT_BITS'(1);
			else if (cmd.echo_inc && echo_q != {ECHO_COUNT_BITS{1'b1}})
				echo_q <= echo_q + ECHO_COUNT_BITS'(1);

			if (cmd.clear)
				rounds_q <= '0;
			else if (cmd.round_end)
				rounds_q <= rounds_inc[ura_pkg::SAMPLE_W-1:0];

			if (cmd.clear)
				sum_q <= '0;
			else if (cmd.round_end)
				sum_q <= sum_add;

			if (cmd.latch)
				dist_q <= quotient;
		end
	end

	// average: sum*16 / (rounds*ticks_per_cm)
	ura_div #(
		.DIVIDEND_W(DVD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({sum_add, 4'b0000}),
		.divisor  (divisor_full[ura_pkg::DIVISOR_W-1:0]),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign distance_nxt = cmd.latch ? quotient : dist_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ura_ctrl.sv -----
// ura_ctrl: measurement phase state machine, issues datapath commands per tick
// depends on ura_pkg
`default_nettype none

module ura_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire logic                start_req,
	input  wire logic                echo_level,
	input  wire ura_pkg::dp_status_t status,
	output ura_pkg::ctrl_cmd_t       cmd,
	output logic                     trigger,
	output logic                     done,
	output logic                     busy_nxt,
	output logic                     hold
);

	ura_pkg::phase_t phase_q;
	ura_pkg::phase_t phase_d;

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= ura_pkg::PH_IDLE;
		else if (fire)
			phase_q <= phase_d;
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			ura_pkg::PH_IDLE: begin
				if (start_req) phase_d = ura_pkg::PH_TRIG;
			end
			ura_pkg::PH_TRIG: begin
				if (status.trig_last) phase_d = ura_pkg::PH_WAIT;
			end
			ura_pkg::PH_WAIT: begin
				if (echo_level) phase_d = ura_pkg::PH_COUNT;
			end
			ura_pkg::PH_COUNT: begin
				if (!echo_level) phase_d = ura_pkg::PH_SETTLE;
			end
			ura_pkg::PH_SETTLE: begin
				if (status.settle_last)
					phase_d = status.rounds_met ? ura_pkg::PH_IDLE : ura_pkg::PH_TRIG;
			end
			default: phase_d = ura_pkg::PH_IDLE;
		endcase
	end

	// commands and per-beat outputs
	always_comb begin
		cmd     = '0;
		trigger = 1'b0;
		done    = 1'b0;
		if (fire) begin
			case (phase_q)
				ura_pkg::PH_IDLE: begin
					cmd.clear = start_req;
				end
				ura_pkg::PH_TRIG: begin
					trigger      = 1'b1;
					cmd.tick_clr = status.trig_last;
					cmd.tick_inc = !status.trig_last;
				end
				ura_pkg::PH_WAIT: begin
					cmd.echo_first = echo_level;
				end
				ura_pkg::PH_COUNT: begin
					cmd.echo_inc  = echo_level;
					cmd.round_end = !echo_level;
					cmd.div_start = !echo_level && status.round_will_meet;
				end
				ura_pkg::PH_SETTLE: begin
					cmd.tick_clr = status.settle_last;
					cmd.tick_inc = !status.settle_last;
					cmd.latch    = status.settle_last && status.rounds_met;
					done         = status.settle_last && status.rounds_met;
				end
				default: ;
			endcase
		end
	end

	assign busy_nxt = (phase_d != ura_pkg::PH_IDLE);

	// last settle tick waits for the quotient
	assign hold = (phase_q == ura_pkg::PH_SETTLE) && status.settle_last &&
		status.rounds_met && status.div_busy;

endmodule

`default_nettype wire

// ----- hw/rtl/ultrasonic_range_averager.sv -----
// ultrasonic_range_averager: top level, joins controller, datapath and result register
// depends on ura_pkg, ura_if, ura_ctrl, ura_dp
//
// Usage: the tick channel carries one beat per microsecond tick with start_req
// and the sampled echo_level. Every accepted tick beat yields exactly one result
// beat (trigger level, busy, done and the latched distance in Q.4 centimetres).
// The cfg channel writes trigger_ticks, sample_count, settle_ticks, ticks_per_cm
// by index 0..3; it is always ready and should only be used while idle.
// A result beat is registered and appears in the cycle after its tick beat is accepted.
// Throughput: one tick per cycle unless a stall or hold drops tick ready. The
// division runs bit-serially from the end of the last echo; if the settle wait
// ends first, the final settle tick is held off until the quotient is ready.
// A registered result stage parts the channels: a new tick is taken while the
// previous result is being taken; when the receiver stalls, the result holds
// and tick ready drops.
// Reset: phase idle, counters and distance zero, registers at their defaults.
`default_nettype none

module ultrasonic_range_averager #(
	parameter int ECHO_COUNT_BITS = 24
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ura_tick_if.sink   tick,
	ura_res_if.source  res,
	ura_cfg_if.sink    cfg
);

	ura_pkg::ctrl_cmd_t  cmd;
	ura_pkg::dp_status_t status;

	logic                       fire;
	logic                       hold;
	logic                       trig_c;
	logic                       done_c;
	logic                       busy_c;
	logic [ura_pkg::DIST_W-1:0] dist_c;

	logic                       res_valid_q;
	logic                       trig_q;
	logic                       busy_q;
	logic                       done_q;
	logic [ura_pkg::DIST_W-1:0] dist_q;

	// tick beat handshake
	assign tick.ready = (!res_valid_q || res.ready) && !hold;
	assign fire       = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	ura_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.start_req  (tick.start_req),
		.echo_level (tick.echo_level),
		.status     (status),
		.cmd        (cmd),
		.trigger    (trig_c),
		.done       (done_c),
		.busy_nxt   (busy_c),
		.hold       (hold)
	);

	ura_dp #(
		.ECHO_COUNT_BITS(ECHO_COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.cmd          (cmd),
		.status       (status),
		.distance_nxt (dist_c)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (fire)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			trig_q <= trig_c;
			busy_q <= busy_c;
			done_q <= done_c;
			dist_q <= dist_c;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.trigger     = trig_q;
	assign res.busy_res    = busy_q;
	assign res.done_res    = done_q;
	assign res.distance_q4 = dist_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ura_checker.sv -----
// ura_checker: port-level assertions for ultrasonic_range_averager, bound to the top
// depends on ura_pkg for the distance width
`default_nettype none

module ura_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       tick_ready,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire logic                       res_trigger,
	input wire logic                       res_busy,
	input wire logic                       res_done,
	input wire logic [ura_pkg::DIST_W-1:0] res_distance
);

	// a finished average ends the sequence
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_done |-> !res_busy)
		else $error("done beat still shows busy");

	// trigger only fires inside a sequence
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_trigger |-> res_busy)
		else $error("trigger high while not busy");

	// a stalled result blocks new ticks
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !tick_ready)
		else $error("tick accepted while result stalled");

	// distance only moves on a done beat
	a_dist_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && $past(res_valid) && $past(res_ready) &&
		res_distance != $past(res_distance) |-> res_done)
		else $error("distance changed without done");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_distance))
		else $error("stalled result changed");

endmodule

bind ultrasonic_range_averager ura_checker u_ura_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_trigger  (res.trigger),
	.res_busy     (res.busy_res),
	.res_done     (res.done_res),
	.res_distance (res.distance_q4)
);

`default_nettype wire

// ----- sim/ura_range_checker.sv -----
// ura_range_checker: predicts every result beat of the ultrasonic range averager
// and compares it field by field; depends on ura_pkg and the channel interfaces in ura_if
`default_nettype none

module ura_range_checker #(
	parameter int ECHO_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	ura_tick_if             tick,
	ura_res_if              res,
	ura_cfg_if              cfg,
	output int              fail_count,
	output int              pending,
	output ura_pkg::phase_t model_ph
);
	timeunit 1ns;
	timeprecision 1ps;

	import ura_pkg::*;

	// register copy
	typedef struct packed {
		logic [TRIG_W-1:0]   trig;
		logic [SAMPLE_W-1:0] samples;
		logic [SETTLE_W-1:0] settle;
		logic [TPC_W-1:0]    tpc;
	} ranger_regs_t;

	// measurement state
	typedef struct packed {
		phase_t              ph;
		logic [SETTLE_W-1:0] ph_ticks;
		logic [ECHO_BITS-1:0] echo_cnt;
		logic [SAMPLE_W-1:0] rounds;
		logic [ECHO_BITS+3:0] sum;
		logic [DIST_W-1:0]   distance;
	} ranger_state_t;

	// one result beat
	typedef struct packed {
		logic              trigger;
		logic              busy;
		logic              done;
		logic [DIST_W-1:0] distance;
	} range_beat_t;

	ranger_regs_t  regs;
	ranger_state_t st;
	range_beat_t   range_q[$];

	// advance the ranger by one microsecond tick
	function automatic range_beat_t step_ranger(input ranger_regs_t r, input ranger_state_t s,
			input logic go, input logic echo, output ranger_state_t nxt);
		range_beat_t          b;
		logic [SAMPLE_W-1:0]  want;
		logic [TPC_W-1:0]     tpc_eff;
		logic [ECHO_BITS+7:0] num;
		logic [ECHO_BITS+7:0] div;
		logic [ECHO_BITS+7:0] quo;
		b = '0;
		// rounds clamp to 1..16, zero scale acts as one
		if (r.samples == '0)
			want = 5'd1;
		else if (r.samples > 5'd16)
			want = 5'd16;
		else
			want = r.samples;
		tpc_eff = (r.tpc == '0) ? 8'd1 : r.tpc;
		case (s.ph)
			PH_IDLE: begin
				if (go) begin
					s.ph = PH_TRIG;
					s.ph_ticks = '0;
					s.rounds = '0;
					s.sum = '0;
					s.echo_cnt = '0;
				end
			end
			PH_TRIG: begin
				b.trigger = 1'b1;
				s.ph_ticks = s.ph_ticks + 1'b1;
				if (s.ph_ticks >= r.trig) begin
					s.ph = PH_WAIT;
					s.ph_ticks = '0;
				end
			end
			PH_WAIT: begin
				if (echo) begin
					s.echo_cnt = ECHO_BITS'(1);
					s.ph = PH_COUNT;
				end
			end
			PH_COUNT: begin
				// counter sticks at all ones
				if (echo) begin
					if (s.echo_cnt != '1)
						s.echo_cnt = s.echo_cnt + 1'b1;
				end else begin
					s.sum = s.sum + s.echo_cnt;
					s.echo_cnt = '0;
					s.rounds = s.rounds + 1'b1;
					s.ph = PH_SETTLE;
					s.ph_ticks = '0;
				end
			end
			PH_SETTLE: begin
				s.ph_ticks = s.ph_ticks + 1'b1;
				if (s.ph_ticks >= r.settle) begin
					s.ph_ticks = '0;
					if (s.rounds >= want) begin
						// average in q4, clipped to the output range
						num = {s.sum, 4'b0000};
						div = want * tpc_eff;
						quo = num / div;
						s.distance = (quo > DIST_MAX) ? DIST_MAX : quo[DIST_W-1:0];
						b.done = 1'b1;
						s.ph = PH_IDLE;
					end else begin
						s.ph = PH_TRIG;
					end
				end
			end
			default: s.ph = PH_IDLE;
		endcase
		b.busy = (s.ph != PH_IDLE);
		b.distance = s.distance;
		nxt = s;
		return b;
	endfunction

	// predict on tick beats, compare on result beats, track register writes
	always @(posedge clk or negedge arst_n) begin : track
		range_beat_t   got;
		range_beat_t   exp_b;
		range_beat_t   nb;
		ranger_state_t nxt;
		int            bad;
		if (!arst_n) begin
			regs <= '{trig: TRIG_RST, samples: SAMPLE_RST, settle: SETTLE_RST, tpc: TPC_RST};
			st <= '0;
			range_q.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			bad = 0;
			if (res.valid && res.ready) begin
				got = '{res.trigger, res.busy_res, res.done_res, res.distance_q4};
				if (range_q.size() == 0) begin
					$error("result beat with no tick beat waiting for it");
					bad++;
				end else begin
					exp_b = range_q.pop_front();
					if (got.trigger !== exp_b.trigger) begin
						$error("trigger: expected %0d, got %0d", exp_b.trigger, got.trigger);
						bad++;
					end
					if (got.busy !== exp_b.busy) begin
						$error("busy_res: expected %0d, got %0d", exp_b.busy, got.busy);
						bad++;
					end
					if (got.done !== exp_b.done) begin
						$error("done_res: expected %0d, got %0d", exp_b.done, got.done);
						bad++;
					end
					if (got.distance !== exp_b.distance) begin
						$error("distance_q4: expected %0d, got %0d", exp_b.distance,
							got.distance);
						bad++;
					end
				end
			end
			if (tick.valid && tick.ready) begin
				nb = step_ranger(regs, st, tick.start_req, tick.echo_level, nxt);
				range_q.push_back(nb);
				st <= nxt;
			end
			// writes to unknown indexes are dropped
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_TRIGGER_TICKS: regs.trig <= cfg.data[TRIG_W-1:0];
					REG_SAMPLE_COUNT:  regs.samples <= cfg.data[SAMPLE_W-1:0];
					REG_SETTLE_TICKS:  regs.settle <= cfg.data[SETTLE_W-1:0];
					REG_TICKS_PER_CM:  regs.tpc <= cfg.data[TPC_W-1:0];
					default: ;
				endcase
			end
			pending <= range_q.size();
			fail_count <= fail_count + bad;
		end
	end

	assign model_ph = st.ph;

endmodule

`default_nettype wire

// ----- sim/ultrasonic_range_averager_tb.sv -----
// ultrasonic_range_averager_tb: drives tick, result and config channels of the ranger
// with directed and random echo sequences; depends on ura_pkg, ura_if and ura_range_checker
`default_nettype none

module ultrasonic_range_averager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ura_pkg::*;

	localparam int ECHO_BITS = 24;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;
	localparam int RANDOM_TICKS = 1000;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   calm;
	int     fail_count;
	int     pending;
	phase_t model_ph;
	int     wait_left;
	int     high_left;
	int     ticks_fed;

	ura_tick_if tick();
	ura_res_if  res();
	ura_cfg_if  cfg();

	always #10 clk = ~clk;

	ultrasonic_range_averager #(.ECHO_COUNT_BITS(ECHO_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.res(res),
		.cfg(cfg)
	);

	ura_range_checker #(.ECHO_BITS(ECHO_BITS)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick),
		.res(res),
		.cfg(cfg),
		.fail_count(fail_count),
		.pending(pending),
		.model_ph(model_ph)
	);

	// result side stalls at random unless in a calm stretch, held low in reset
	always @(posedge clk) begin
		res.ready <= arst_n && (calm || ($urandom_range(99) >= 16));
	end

	// one tick beat, with a random gap ahead of it
	task automatic send_tick(input logic go, input logic echo);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 16)
				gap++;
		if (gap != 0) begin
			tick.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick.valid <= 1'b1;
		tick.start_req <= go;
		tick.echo_level <= echo;
		do @(posedge clk); while (!tick.ready);
	endtask

	// next echo pulse shape: delay after trigger, then high length
	task automatic arm_echo;
		wait_left = $urandom_range(6);
		high_left = ($urandom_range(15) == 0) ? $urandom_range(100, 700) : $urandom_range(25);
	endtask

	// tick shaped by the predicted phase; echo level is noise where it is ignored
	task automatic feed_tick(input bit may_start);
		logic go;
		logic echo;
		go = 1'b0;
		echo = 1'($urandom_range(1));
		case (model_ph)
			PH_IDLE: go = may_start && ($urandom_range(99) < 30);
			PH_WAIT: begin
				go = may_start && ($urandom_range(99) < 5);
				if (wait_left != 0) begin
					wait_left--;
					echo = 1'b0;
				end else begin
					echo = 1'b1;
				end
			end
			PH_COUNT: begin
				go = may_start && ($urandom_range(99) < 5);
				if (high_left != 0) begin
					high_left--;
					echo = 1'b1;
				end else begin
					echo = 1'b0;
					arm_echo();
				end
			end
			default: go = may_start && ($urandom_range(99) < 10);
		endcase
		ticks_fed++;
		send_tick(go, echo);
	endtask

	// run the current sequence out without new starts
	task automatic finish_measurement;
		do feed_tick(1'b0); while (model_ph != PH_IDLE);
	endtask

	// stop ticks and let every result beat come back
	task automatic wait_results_done;
		tick.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// config beat; valid stays up for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// value with junk above the register width now and then
	function automatic logic [CFG_DATA_W-1:0] dress(input int unsigned val, input int w);
		int unsigned d;
		d = val;
		if ($urandom_range(3) == 0)
			d = d | ($urandom() << w);
		return d[CFG_DATA_W-1:0];
	endfunction

	// random register set; settle always rewritten
	task automatic pick_setup;
		int unsigned v;
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(7))
				0: v = 0;
				1: v = 255;
				default: v = $urandom_range(1, 12);
			endcase
			write_reg(REG_TRIGGER_TICKS, dress(v, TRIG_W));
		end
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(7))
				0: v = 0;
				1: v = 16;
				2: v = $urandom_range(17, 31);
				default: v = $urandom_range(1, 4);
			endcase
			write_reg(REG_SAMPLE_COUNT, dress(v, SAMPLE_W));
		end
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(7))
				0: v = 0;
				1: v = 255;
				default: v = $urandom_range(1, 255);
			endcase
			write_reg(REG_TICKS_PER_CM, dress(v, TPC_W));
		end
		case ($urandom_range(7))
			0: v = 0;
			1: v = $urandom_range(100, 400);
			default: v = $urandom_range(1, 40);
		endcase
		write_reg(REG_SETTLE_TICKS, v[CFG_DATA_W-1:0]);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		int lap;
		int n;
		tick.valid <= 1'b0;
		tick.start_req <= 1'b0;
		tick.echo_level <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		arst_n <= 1'b0;
		calm <= 1'b0;
		ticks_fed = 0;
		arm_echo();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle noise under reset values
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		wait_results_done();

		// zero trigger, zero samples, zero settle, zero scale, spare index
		write_reg(REG_TRIGGER_TICKS, 20'hABC00);
		write_reg(REG_SAMPLE_COUNT, '0);
		write_reg(REG_SETTLE_TICKS, '0);
		write_reg(REG_TICKS_PER_CM, '0);
		write_reg(REG_SPARE, 20'hFFFFF);
		cfg.valid <= 1'b0;
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		finish_measurement();
		wait_results_done();

		// longest trigger, largest scale
		write_reg(REG_TRIGGER_TICKS, 20'd255);
		write_reg(REG_SAMPLE_COUNT, 20'd1);
		write_reg(REG_SETTLE_TICKS, 20'd1);
		write_reg(REG_TICKS_PER_CM, 20'd255);
		cfg.valid <= 1'b0;
		send_tick(1'b1, 1'b0);
		finish_measurement();
		wait_results_done();

		// largest settle and oversized sample count, written while idle only
		write_reg(REG_SETTLE_TICKS, 20'hFFFFF);
		write_reg(REG_SAMPLE_COUNT, 20'h0003F);
		cfg.valid <= 1'b0;
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		wait_results_done();

		// random measurements under random settings, first lap with no idling
		ticks_fed = 0;
		lap = 0;
		while (ticks_fed < RANDOM_TICKS) begin
			if (lap == 0)
				calm <= 1'b1;
			pick_setup();
			n = $urandom_range(40, 200);
			repeat (n) feed_tick(1'b1);
			finish_measurement();
			wait_results_done();
			if (calm)
				calm <= 1'b0;
			lap++;
		end

		// drain, then a short quiet tail for stray beats
		wait_results_done();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hang guard
	initial begin
		#80_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
